/* rtl/assert_macros.svh */
// Assertion helpers used by the RTL.
// ASSERT_IMPL: when ante holds at a clock edge, cons holds at the same edge.
// ASSERT_NEXT: when ante holds at a clock edge, cons holds at the next edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/kcl_pkg.sv */
`timescale 1ns / 1ps

package kcl_pkg;

    // Entry buffer geometry
    localparam int MAX_LEN    = 5;
    localparam int CNT_W      = $clog2(MAX_LEN + 1);
    localparam int KEY_W      = 4;
    localparam int MASTER_LEN = 5;

    // Field widths
    localparam int LOCK_W  = 16;
    localparam int ATT_W   = 3;
    localparam int EV_W    = 3;
    localparam int LEN_W   = 3;
    localparam int PHASE_W = 2;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = LOCK_W;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT_TICKS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ATTEMPTS  = 1'b1;

    // Register reset values
    localparam logic [LOCK_W-1:0] RST_LOCKOUT_TICKS = 16'd30000;
    localparam logic [ATT_W-1:0]  RST_MAX_ATTEMPTS  = 3'd3;

    // Special keys
    localparam logic [KEY_W-1:0] KEY_A    = 4'd3;
    localparam logic [KEY_W-1:0] KEY_B    = 4'd7;
    localparam logic [KEY_W-1:0] KEY_HASH = 4'd14;

    // Item modes
    localparam logic MODE_KEY  = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    // Reported phase codes
    localparam logic [PHASE_W-1:0] PHASE_SET   = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_ENTRY = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_LOCK  = 2'd2;

    // Lock phase state
    typedef enum logic [2:0] {
        PH_SET   = 3'b001,
        PH_ENTRY = 3'b010,
        PH_LOCK  = 3'b100
    } t_phase;

    // Event codes
    typedef enum logic [EV_W-1:0] {
        EV_NONE      = 3'd0,
        EV_CODE_SET  = 3'd1,
        EV_GRANTED   = 3'd2,
        EV_MASTER    = 3'd3,
        EV_WRONG     = 3'd4,
        EV_LOCKED    = 3'd5,
        EV_LOCK_OVER = 3'd6
    } t_event;

    typedef logic [MAX_LEN-1:0][KEY_W-1:0] t_keys;

    typedef struct packed {
        logic [LOCK_W-1:0] lockout_ticks;
        logic [ATT_W-1:0]  max_attempts;
    } t_cfg;

    typedef struct packed {
        logic             mode;
        logic [KEY_W-1:0] key_code;
    } t_item;

    typedef struct packed {
        logic [EV_W-1:0]    event_res;
        logic [ATT_W-1:0]   attempts_left;
        logic [LEN_W-1:0]   entry_length;
        logic [PHASE_W-1:0] phase_now;
    } t_result;

    typedef struct packed {
        logic code_match;
        logic master;
    } t_match;

endpackage

/* rtl/kcl_in_if.sv */
`timescale 1ns / 1ps

// Request channel: one key press or timer tick per transfer
interface kcl_in_if import kcl_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             mode;
    logic [KEY_W-1:0] key_code;

    modport source (output valid, output mode, output key_code, input ready);
    modport sink   (input valid, input mode, input key_code, output ready);
endinterface

/* rtl/kcl_out_if.sv */
`timescale 1ns / 1ps

// Result channel: one result per request
interface kcl_out_if import kcl_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [EV_W-1:0]    event_res;
    logic [ATT_W-1:0]   attempts_left;
    logic [LEN_W-1:0]   entry_length;
    logic [PHASE_W-1:0] phase_now;

    modport source (output valid, output event_res, output attempts_left,
                    output entry_length, output phase_now, input ready);
    modport sink   (input valid, input event_res, input attempts_left,
                    input entry_length, input phase_now, output ready);
endinterface

/* rtl/keypad_code_lock.sv */
// Keypad code lock. Each request is a key press or a timer tick and gives exactly
// one result: event, attempts left, entry length and phase. The block takes one
// request per cycle while its results are taken. A result is presented once its
// request has passed the input register and its result has been loaded into the
// result register. While a result waits, one more request can still be taken into
// the input register; further requests stall until the waiting result is taken.
// The whole step (entry update, five-key compare, attempt and lockout bookkeeping)
// is one short combinational pass in the core between those two registers. The two
// configuration registers (lockout ticks, max attempts) are written through a plain
// write port and should only change while the lock is idle.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module keypad_code_lock import kcl_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    kcl_in_if.sink                i_req,
    kcl_out_if.source             o_res
);

    t_cfg    r_cfg;
    logic    r_in_valid;
    t_item   r_item;
    logic    r_out_valid;
    t_result r_result;
    t_result step_result;
    logic    advance;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lockout_ticks <= RST_LOCKOUT_TICKS;
            r_cfg.max_attempts  <= RST_MAX_ATTEMPTS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LOCKOUT_TICKS: r_cfg.lockout_ticks <= i_cfg_data;
                CFG_MAX_ATTEMPTS:  r_cfg.max_attempts  <= ATT_W'(i_cfg_data);
                default: ;
            endcase
        end
    end

    // Pipeline flow: input stage moves when the result register is free or draining
    assign advance     = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_req.ready = !r_in_valid || advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_item.mode     <= i_req.mode;
            r_item.key_code <= i_req.key_code;
        end
    end

    kcl_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_step   (advance),
        .i_item   (r_item),
        .o_result (step_result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= step_result;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.event_res     = r_result.event_res;
    assign o_res.attempts_left = r_result.attempts_left;
    assign o_res.entry_length  = r_result.entry_length;
    assign o_res.phase_now     = r_result.phase_now;

    // Checks
    `ASSERT_NEXT(a_step_gives_result, i_clk, i_rst_n, advance, r_out_valid)
    `ASSERT_IMPL(a_lock_no_attempts, i_clk, i_rst_n,
        o_res.valid && (o_res.phase_now == PHASE_LOCK), o_res.attempts_left == '0)
    `ASSERT_IMPL(a_entry_short, i_clk, i_rst_n,
        o_res.valid, int'(o_res.entry_length) < MAX_LEN)
    `ASSERT_IMPL(a_finish_clears, i_clk, i_rst_n,
        o_res.valid && (o_res.event_res != EV_NONE) && (o_res.event_res != EV_LOCK_OVER),
        o_res.entry_length == '0)

endmodule

/* rtl/kcl_match.sv */
`timescale 1ns / 1ps

// Parallel compare of the entry against the stored code and the master code
module kcl_match import kcl_pkg::*; (
    input  t_keys            i_keys,
    input  logic [CNT_W-1:0] i_count,
    input  t_keys            i_stored,
    input  logic [CNT_W-1:0] i_stored_len,
    output t_match           o_match
);

    always_comb begin
        o_match.code_match = (i_count == i_stored_len);
        o_match.master     = (MASTER_LEN <= MAX_LEN) && (int'(i_count) == MASTER_LEN);
        for (int i = 0; i < MAX_LEN; i++) begin
            // only keys inside the entry take part
            if ((CNT_W'(i) < i_count) && (i_keys[i] != i_stored[i])) begin
                o_match.code_match = 1'b0;
            end
            if ((i < MASTER_LEN) && (i_keys[i] != KEY_A)) begin
                o_match.master = 1'b0;
            end
        end
    end

endmodule

/* rtl/kcl_core.sv */
`timescale 1ns / 1ps

// Lock state and the single-pass step for one request
module kcl_core import kcl_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_step,
    input  t_item   i_item,
    output t_result o_result
);

    t_phase            r_phase, n_phase;
    t_keys             r_keys, n_keys;
    logic [CNT_W-1:0]  r_count, n_count;
    t_keys             r_stored, n_stored;
    logic [CNT_W-1:0]  r_stored_len, n_stored_len;
    logic [ATT_W-1:0]  r_attempts, n_attempts;
    logic [LOCK_W-1:0] r_lock_cnt, n_lock_cnt;

    t_keys             keys_post;
    logic [CNT_W-1:0]  count_post;
    logic              is_key, is_digit, finish;
    logic [ATT_W-1:0]  full_attempts;
    t_match            match;
    t_event            ev;
    logic [PHASE_W-1:0] phase_code;

    assign full_attempts = (i_cfg.max_attempts == '0) ? ATT_W'(1) : i_cfg.max_attempts;

    assign is_key   = (i_item.mode == MODE_KEY) && (r_phase != PH_LOCK);
    assign is_digit = is_key && (i_item.key_code != KEY_B) && (i_item.key_code != KEY_HASH);

    // Entry buffer after this key (append or backspace)
    always_comb begin
        keys_post  = r_keys;
        count_post = r_count;
        if (is_digit && (int'(r_count) < MAX_LEN)) begin
            for (int i = 0; i < MAX_LEN; i++) begin
                if (CNT_W'(i) == r_count) begin
                    keys_post[i] = i_item.key_code;
                end
            end
            count_post = r_count + CNT_W'(1);
        end else if (is_key && (i_item.key_code == KEY_B) && (r_count != '0)) begin
            for (int i = 0; i < MAX_LEN; i++) begin
                if (CNT_W'(i) == r_count - CNT_W'(1)) begin
                    keys_post[i] = '0;
                end
            end
            count_post = r_count - CNT_W'(1);
        end
    end

    assign finish = (is_key && (i_item.key_code == KEY_HASH))
                 || (is_digit && (int'(count_post) >= MAX_LEN));

    kcl_match u_match (
        .i_keys       (keys_post),
        .i_count      (count_post),
        .i_stored     (r_stored),
        .i_stored_len (r_stored_len),
        .o_match      (match)
    );

    // Next state and event
    always_comb begin
        n_phase      = r_phase;
        n_keys       = keys_post;
        n_count      = count_post;
        n_stored     = r_stored;
        n_stored_len = r_stored_len;
        n_attempts   = r_attempts;
        n_lock_cnt   = r_lock_cnt;
        ev           = EV_NONE;
        if (i_item.mode == MODE_TICK) begin
            if (r_phase == PH_LOCK) begin
                if (r_lock_cnt <= LOCK_W'(1)) begin
                    n_lock_cnt = '0;
                    n_phase    = PH_ENTRY;
                    n_attempts = full_attempts;
                    ev         = EV_LOCK_OVER;
                end else begin
                    n_lock_cnt = r_lock_cnt - LOCK_W'(1);
                end
            end
        end else if (finish) begin
            n_keys  = '0;
            n_count = '0;
            if (r_phase == PH_SET) begin
                n_stored     = keys_post;
                n_stored_len = count_post;
                n_phase      = PH_ENTRY;
                n_attempts   = full_attempts;
                ev           = EV_CODE_SET;
            end else if (match.code_match) begin
                ev = EV_GRANTED;
            end else if (match.master) begin
                n_phase = PH_SET;
                ev      = EV_MASTER;
            end else if (r_attempts <= ATT_W'(1)) begin
                n_attempts = '0;
                n_phase    = PH_LOCK;
                n_lock_cnt = i_cfg.lockout_ticks;
                ev         = EV_LOCKED;
            end else begin
                n_attempts = r_attempts - ATT_W'(1);
                ev         = EV_WRONG;
            end
        end
    end

    // Phase as reported
    always_comb begin
        unique case (n_phase)
            PH_SET:   phase_code = PHASE_SET;
            PH_ENTRY: phase_code = PHASE_ENTRY;
            PH_LOCK:  phase_code = PHASE_LOCK;
            default:  phase_code = PHASE_SET;
        endcase
    end

    assign o_result.event_res     = ev;
    assign o_result.attempts_left = n_attempts;
    assign o_result.entry_length  = LEN_W'(n_count);
    assign o_result.phase_now     = phase_code;

    // State update on each accepted step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_SET;
            r_keys       <= '0;
            r_count      <= '0;
            r_stored     <= '0;
            r_stored_len <= '0;
            r_attempts   <= RST_MAX_ATTEMPTS;
            r_lock_cnt   <= '0;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_keys       <= n_keys;
            r_count      <= n_count;
            r_stored     <= n_stored;
            r_stored_len <= n_stored_len;
            r_attempts   <= n_attempts;
            r_lock_cnt   <= n_lock_cnt;
        end
    end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps

import kcl_pkg::*;

// Lock behavior predictor plus the queue of results still owed by the block
class lock_scoreboard;
    logic [PHASE_W-1:0] phase;
    logic [KEY_W-1:0]   entry[MAX_LEN];
    int unsigned        entry_cnt;
    logic [KEY_W-1:0]   code[MAX_LEN];
    int unsigned        code_len;
    logic [ATT_W-1:0]   attempts;
    logic [LOCK_W-1:0]  lock_cnt;
    logic [LOCK_W-1:0]  lockout_ticks;
    logic [ATT_W-1:0]   max_attempts;
    t_result            owed_q[$];
    int                 errors;
    int                 active_items;

    function new();
        phase         = PHASE_SET;
        entry_cnt     = 0;
        code_len      = 0;
        attempts      = RST_MAX_ATTEMPTS;
        lock_cnt      = '0;
        lockout_ticks = RST_LOCKOUT_TICKS;
        max_attempts  = RST_MAX_ATTEMPTS;
        errors        = 0;
        active_items  = 0;
        for (int i = 0; i < MAX_LEN; i++) begin
            entry[i] = '0;
            code[i]  = '0;
        end
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        if (idx == CFG_LOCKOUT_TICKS)
            lockout_ticks = val[LOCK_W-1:0];
        else if (idx == CFG_MAX_ATTEMPTS)
            max_attempts = val[ATT_W-1:0];
    endfunction

    // A zero attempt limit still allows one try
    function logic [ATT_W-1:0] full_attempts();
        return (max_attempts == 0) ? ATT_W'(1) : max_attempts;
    endfunction

    function bit entry_matches();
        if (entry_cnt != code_len)
            return 1'b0;
        for (int i = 0; i < entry_cnt && i < MAX_LEN; i++)
            if (entry[i] != code[i])
                return 1'b0;
        return 1'b1;
    endfunction

    function bit entry_is_master();
        if (entry_cnt != MASTER_LEN)
            return 1'b0;
        for (int i = 0; i < MASTER_LEN && i < MAX_LEN; i++)
            if (entry[i] != KEY_A)
                return 1'b0;
        return 1'b1;
    endfunction

    // Entry complete: store, grant, master reset, or charge an attempt
    function t_event close_entry();
        t_event ev;
        if (phase == PHASE_SET) begin
            for (int i = 0; i < MAX_LEN; i++)
                code[i] = entry[i];
            code_len = entry_cnt;
            phase    = PHASE_ENTRY;
            attempts = full_attempts();
            ev       = EV_CODE_SET;
        end else if (entry_matches()) begin
            // match wins even over a stored all-A code
            ev = EV_GRANTED;
        end else if (entry_is_master()) begin
            phase = PHASE_SET;
            ev    = EV_MASTER;
        end else if (attempts <= 1) begin
            attempts = '0;
            phase    = PHASE_LOCK;
            lock_cnt = lockout_ticks;
            ev       = EV_LOCKED;
        end else begin
            attempts = attempts - 1'b1;
            ev       = EV_WRONG;
        end
        for (int i = 0; i < MAX_LEN; i++)
            entry[i] = '0;
        entry_cnt = 0;
        return ev;
    endfunction

    function void note_request(logic m, logic [KEY_W-1:0] k);
        t_event  ev;
        t_result res;
        ev = EV_NONE;
        if (m == MODE_TICK) begin
            // ticks only matter while locked out
            if (phase == PHASE_LOCK) begin
                active_items++;
                if (lock_cnt <= 1) begin
                    lock_cnt = '0;
                    phase    = PHASE_ENTRY;
                    attempts = full_attempts();
                    ev       = EV_LOCK_OVER;
                end else begin
                    lock_cnt = lock_cnt - 1'b1;
                end
            end
        end else if (phase != PHASE_LOCK) begin
            active_items++;
            if (k == KEY_B) begin
                if (entry_cnt > 0) begin
                    entry_cnt--;
                    entry[entry_cnt] = '0;
                end
            end else if (k == KEY_HASH) begin
                ev = close_entry();
            end else begin
                if (entry_cnt < MAX_LEN) begin
                    entry[entry_cnt] = k;
                    entry_cnt++;
                end
                if (entry_cnt >= MAX_LEN)
                    ev = close_entry();
            end
        end
        res.event_res     = ev;
        res.attempts_left = attempts;
        res.entry_length  = LEN_W'(entry_cnt);
        res.phase_now     = phase;
        owed_q.push_back(res);
    endfunction

    task report(string msg);
        if (errors < 100)
            $display("[%0t] mismatch: %s", $realtime, msg);
        errors++;
    endtask

    task check_result(t_result got);
        t_result want;
        if (owed_q.size() == 0) begin
            report("result with no request outstanding");
            return;
        end
        want = owed_q.pop_front();
        if (got.event_res !== want.event_res)
            report($sformatf("event_res got %0d want %0d", got.event_res, want.event_res));
        if (got.attempts_left !== want.attempts_left)
            report($sformatf("attempts_left got %0d want %0d",
                             got.attempts_left, want.attempts_left));
        if (got.entry_length !== want.entry_length)
            report($sformatf("entry_length got %0d want %0d",
                             got.entry_length, want.entry_length));
        if (got.phase_now !== want.phase_now)
            report($sformatf("phase_now got %0d want %0d", got.phase_now, want.phase_now));
    endtask
endclass

module testbench;
    localparam int WATCHDOG_LIMIT = 4000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    kcl_in_if  req_if ();
    kcl_out_if res_if ();

    keypad_code_lock dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_if),
        .o_res      (res_if)
    );

    lock_scoreboard board;
    int             hold_cycles = 0;
    int             burst_left  = 0;
    int             stall_left  = 0;
    int             idle_cycles = 0;
    bit             quiet       = 1'b0;

    // 2 ns clock
    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [KEY_W-1:0] rand_digit();
        logic [KEY_W-1:0] k;
        do
            k = KEY_W'($urandom_range(0, 15));
        while (k == KEY_B || k == KEY_HASH);
        return k;
    endfunction

    // Offer one request and hold it until the block takes it
    task automatic send_request(input logic m, input logic [KEY_W-1:0] k);
        int gap;
        gap = (quiet || burst_left > 0) ? 0 : pick_gap();
        if (burst_left > 0)
            burst_left--;
        @(negedge i_clk);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.valid    <= 1'b1;
        req_if.mode     <= m;
        req_if.key_code <= k;
        do
            @(posedge i_clk);
        while (!req_if.ready);
        board.note_request(m, k);
    endtask

    task automatic send_key(input logic [KEY_W-1:0] k);
        send_request(MODE_KEY, k);
    endtask

    task automatic send_tick();
        send_request(MODE_TICK, KEY_W'($urandom_range(0, 15)));
    endtask

    // Drain every owed result, then let the pipeline settle
    task automatic wait_idle();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (board.owed_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic configure(input logic [LOCK_W-1:0] ticks, input logic [ATT_W-1:0] tries);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_LOCKOUT_TICKS;
        i_cfg_data <= ticks;
        @(posedge i_clk);
        board.write_reg(CFG_LOCKOUT_TICKS, ticks);
        @(negedge i_clk);
        // upper data bits are don't-care for the attempt register
        i_cfg_idx  <= CFG_MAX_ATTEMPTS;
        i_cfg_data <= {(CFG_DATA_W - ATT_W)'($urandom), tries};
        @(posedge i_clk);
        board.write_reg(CFG_MAX_ATTEMPTS, {(CFG_DATA_W - ATT_W)'(0), tries});
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // One random keypad sequence, shaped by the current phase
    task automatic run_sequence();
        int               r;
        int               n;
        bit               typo;
        int unsigned      snap_len;
        logic [KEY_W-1:0] snap[MAX_LEN];
        logic [KEY_W-1:0] k;
        r = $urandom_range(0, 99);
        if (board.phase == PHASE_LOCK) begin
            if (r < 80) begin
                n = $urandom_range(1, int'(board.lock_cnt) + 1);
                repeat (n) send_tick();
            end else begin
                send_request(1'($urandom), KEY_W'($urandom));
            end
            return;
        end
        if (board.phase == PHASE_ENTRY && r < 40) begin
            // try the stored code, sometimes with a typo or a corrected slip
            snap_len = board.code_len;
            for (int i = 0; i < MAX_LEN; i++)
                snap[i] = board.code[i];
            typo = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < snap_len; i++) begin
                k = snap[i];
                if (typo && i == 0)
                    k = rand_digit();
                if ($urandom_range(0, 7) == 0) begin
                    send_key(rand_digit());
                    send_key(KEY_B);
                end
                send_key(k);
            end
            if (snap_len < MAX_LEN)
                send_key(KEY_HASH);
        end else if (r < 50) begin
            // master sequence, or a near miss ended early
            n = ($urandom_range(0, 3) == 0) ? 4 : MASTER_LEN;
            repeat (n) send_key(KEY_A);
            if (n < MASTER_LEN)
                send_key(KEY_HASH);
        end else if (r < 80) begin
            n = $urandom_range(0, MAX_LEN);
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(0, 5) == 0)
                    send_key(KEY_B);
                send_key(rand_digit());
            end
            if (n < MAX_LEN)
                send_key(KEY_HASH);
        end else if (r < 90) begin
            n = $urandom_range(1, 3);
            repeat (n) send_tick();
        end else begin
            n = $urandom_range(1, 4);
            repeat (n) send_request(1'($urandom), KEY_W'($urandom));
        end
    endtask

    task automatic run_phase(input logic [LOCK_W-1:0] ticks, input logic [ATT_W-1:0] tries,
                             input int count, input bit calm, input bit pressure);
        int target;
        wait_idle();
        configure(ticks, tries);
        quiet = calm;
        if (pressure) begin
            // receiver holds off while the sender keeps offering
            hold_cycles = 200;
            burst_left  = 80;
        end
        target = board.active_items + count;
        while (board.active_items < target)
            run_sequence();
        quiet = 1'b0;
    endtask

    // Result side: random back-pressure, check on every accepted result
    initial begin
        t_result got;
        res_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                res_if.ready <= 1'b0;
                hold_cycles--;
            end else if (stall_left > 0) begin
                res_if.ready <= 1'b0;
                stall_left--;
            end else begin
                res_if.ready <= 1'b1;
                stall_left = quiet ? 0 : pick_gap();
            end
            @(posedge i_clk);
            if (res_if.valid && res_if.ready) begin
                got.event_res     = res_if.event_res;
                got.attempts_left = res_if.attempts_left;
                got.entry_length  = res_if.entry_length;
                got.phase_now     = res_if.phase_now;
                board.check_result(got);
            end
        end
    end

    // Watchdog: cycles with no transfer on either channel
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // Main stimulus
    initial begin
        board           = new();
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = '0;
        i_cfg_data      = '0;
        req_if.valid    = 1'b0;
        req_if.mode     = MODE_KEY;
        req_if.key_code = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset register values still in force
        send_tick();                        // tick outside lockout
        send_key(KEY_B);                    // backspace on an empty entry
        send_key(KEY_HASH);                 // empty entry stores an empty code
        send_key(KEY_HASH);                 // empty entry matches the empty code
        repeat (MASTER_LEN) send_key(KEY_A);  // master sequence back to set phase
        repeat (MASTER_LEN) send_key(KEY_A);  // store the all-A code
        repeat (MASTER_LEN) send_key(KEY_A);  // matching wins over the master sequence

        // Directed: short lockout, one attempt after restore
        wait_idle();
        configure(16'd2, 3'd1);
        send_key(4'd0);
        send_key(4'd15);
        send_key(KEY_HASH);                 // wrong
        send_key(KEY_HASH);                 // wrong, last attempt
        send_key(KEY_HASH);                 // locked
        send_key(4'd5);                     // key ignored while locked
        send_tick();
        send_tick();                        // lockout over, attempts restored
        send_key(KEY_HASH);                 // single attempt: locks at once
        send_tick();
        send_tick();

        // Random phases over several register settings
        run_phase(16'd3, 3'd3, 250, 1'b1, 1'b0);
        run_phase(16'd1, 3'd7, 300, 1'b0, 1'b1);
        run_phase(LOCK_W'($urandom_range(1, 40)), ATT_W'($urandom_range(1, 7)), 300, 1'b0, 1'b0);
        run_phase(LOCK_W'($urandom_range(1, 40)), ATT_W'($urandom_range(1, 7)), 300, 1'b0, 1'b0);
        run_phase(LOCK_W'($urandom_range(1, 40)), ATT_W'($urandom_range(1, 7)), 300, 1'b0, 1'b0);

        // Long lockout: lock once and tick it all the way out
        wait_idle();
        quiet = 1'b1;
        while (board.phase == PHASE_LOCK)
            send_tick();
        wait_idle();
        configure(16'd100, 3'd1);
        while (board.phase != PHASE_LOCK) begin
            if (board.phase == PHASE_ENTRY && board.code_len == 0)
                send_key(rand_digit());
            send_key(KEY_HASH);
        end
        while (board.phase == PHASE_LOCK)
            send_tick();
        quiet = 1'b0;

        wait_idle();
        repeat (6) @(posedge i_clk);
        if (board.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

/* sim.f */
+incdir+rtl
rtl/kcl_pkg.sv
rtl/kcl_in_if.sv
rtl/kcl_out_if.sv
rtl/kcl_match.sv
rtl/kcl_core.sv
rtl/keypad_code_lock.sv
bench/testbench.sv
